/* hdl/ddr_pkg.sv */
package ddr_pkg;

    // field widths
    localparam int THR_W   = 16;
    localparam int IVL_W   = 16;
    localparam int SG_W    = 16;
    localparam int TG_W    = 28;
    localparam int LAT_W   = 48;
    localparam int LON_W   = 49;
    localparam int HEAD_W  = 32;
    localparam int SPEED_W = 18;
    localparam int DIST_W  = 34;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 152;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TG_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 1'd1;
    localparam logic [SG_W-1:0] SPEED_GAIN_RST = 16'd10995;
    localparam logic [TG_W-1:0] TURN_GAIN_RST  = 28'd10737418;

    // arithmetic constants
    localparam int TRIG_BITS    = 16;
    localparam int TRIG_W       = TRIG_BITS + 2;
    localparam int GAIN_SH      = 14;
    localparam int Q_ONE        = 16384;
    localparam int CORDIC_ITERS = 28;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_Z_W   = 32;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam longint CORDIC_K0 = 64'sd652032874;
    localparam longint LAT_MAX   = 64'sd98956046499840;
    localparam longint LON_MAX   = 64'sd197912092999680;

    // shared multiplier
    localparam int MUL_A_W = DIST_W + 1;
    localparam int MUL_B_W = (TRIG_W > 18) ? TRIG_W : 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // microcode
    localparam int STEP_W = 4;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TURN,
        MUL_SPEED,
        MUL_DIST,
        MUL_LAT,
        MUL_LON
    } mul_sel_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_HEAD,
        UPD_SPEED,
        UPD_DIST,
        UPD_TRIG,
        UPD_LAT,
        UPD_LON
    } upd_sel_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_EMIT
    } seq_op_t;

    typedef struct packed {
        mul_sel_t          mul_sel;
        upd_sel_t          upd_sel;
        logic              cordic_init;
        logic              cordic_step;
        seq_op_t           seq_op;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam ctrl_word_t CTRL_IDLE = '{
        mul_sel:     MUL_NONE,
        upd_sel:     UPD_NONE,
        cordic_init: 1'b0,
        cordic_step: 1'b0,
        seq_op:      SEQ_NEXT,
        target:      '0
    };

    typedef struct packed {
        logic busy;
        logic emit;
    } seq_stat_t;

    typedef struct packed {
        logic cordic_last;
    } dp_stat_t;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/differential_drive_dead_reckoning.sv */
// channel   direction  transaction                   contents
// s_*       in         one tick                      left and right throttle, interval_ms
// m_*       out        position after the tick       latitude, longitude, heading, speed
// cfg_*     in         register write, no handshake  speed_gain (0), turn_gain (1)
//
// a tick runs as ten microcode steps, one of which repeats for the 28 cordic rotations;
// s_tready stays low while the program runs
// the single shared 35x18 multiplier and the one-rotation-per-cycle cordic set its length
// the result sits in an output register, so the next tick is accepted while it waits
// if that register is still full at the last step, the sequencer holds there until it drains
// rst_n clears heading, speed and position to zero and loads the gain reset values
module differential_drive_dead_reckoning (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tick: left throttle [15:0], right throttle [31:16], interval_ms [47:32]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ddr_pkg::IN_DATA_W-1:0]         s_tdata,
    // result: latitude [47:0], longitude [96:48], heading [128:97], speed [146:129]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ddr_pkg::OUT_DATA_W-1:0]        m_tdata,
    // register write
    input  logic                                  cfg_we,
    input  logic [ddr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ddr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PAD_W = ddr_pkg::OUT_DATA_W - ddr_pkg::LAT_W - ddr_pkg::LON_W
                           - ddr_pkg::HEAD_W - ddr_pkg::SPEED_W;

    ddr_pkg::ctrl_word_t                   ctrl;
    ddr_pkg::seq_stat_t                    seq_stat;
    ddr_pkg::dp_stat_t                     dp_stat;

    logic                                  accept;
    logic                                  out_free;
    logic signed [ddr_pkg::LAT_W-1:0]      latitude;
    logic signed [ddr_pkg::LON_W-1:0]      longitude;
    logic        [ddr_pkg::HEAD_W-1:0]     heading;
    logic signed [ddr_pkg::SPEED_W-1:0]    speed;

    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [ddr_pkg::OUT_DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    // one tick in flight at a time; the output register decouples the result side
    assign s_tready = !seq_stat.busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    ddr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .out_free (out_free),
        .dp_stat  (dp_stat),
        .ctrl     (ctrl),
        .seq_stat (seq_stat)
    );

    ddr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .thr_left    (signed'(s_tdata[15:0])),
        .thr_right   (signed'(s_tdata[31:16])),
        .interval_ms (s_tdata[47:32]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl        (ctrl),
        .dp_stat     (dp_stat),
        .latitude    (latitude),
        .longitude   (longitude),
        .heading     (heading),
        .speed       (speed)
    );

    // output register: loaded on the last step, cleared when the result transaction completes
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (seq_stat.emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {PAD_W'(0), speed, heading, longitude, latitude};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an accepted tick starts the program on the next cycle
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> seq_stat.busy)
        else $error("accepted tick did not start the sequencer");

    // a result is only written into an empty or draining output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result emitted over a pending one");

    // a result appears only from the last program step
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(seq_stat.emit))
        else $error("output valid without emit");

    // the sequencer is idle when it finishes a tick
    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.emit |=> !seq_stat.busy)
        else $error("sequencer still busy after emit");

endmodule

/* hdl/ddr_sequencer.sv */
module ddr_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 out_free,
    input  ddr_pkg::dp_stat_t    dp_stat,
    output ddr_pkg::ctrl_word_t  ctrl,
    output ddr_pkg::seq_stat_t   seq_stat
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // program steps
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_TURN   = 4'd0;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_HEAD   = 4'd1;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_SPEED  = 4'd2;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_DIST   = 4'd3;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_ROTATE = 4'd4;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_TRIG   = 4'd5;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_LAT    = 4'd6;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_LON    = 4'd7;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_MOVE   = 4'd8;
    localparam logic [ddr_pkg::STEP_W-1:0] STEP_EMIT   = 4'd9;

    state_t                       state_reg;
    logic [ddr_pkg::STEP_W-1:0]   pc_reg;
    ddr_pkg::ctrl_word_t          rom_word;
    logic                         emit;

    // control store
    always_comb
    begin
        rom_word = ddr_pkg::CTRL_IDLE;
        unique case (pc_reg)
            STEP_TURN:
            begin
                rom_word.mul_sel = ddr_pkg::MUL_TURN;
            end
            STEP_HEAD:
            begin
                rom_word.upd_sel = ddr_pkg::UPD_HEAD;
                rom_word.mul_sel = ddr_pkg::MUL_SPEED;
            end
            STEP_SPEED:
            begin
                rom_word.upd_sel     = ddr_pkg::UPD_SPEED;
                rom_word.cordic_init = 1'b1;
            end
            STEP_DIST:
            begin
                rom_word.mul_sel = ddr_pkg::MUL_DIST;
            end
            STEP_ROTATE:
            begin
                rom_word.upd_sel     = ddr_pkg::UPD_DIST;
                rom_word.cordic_step = 1'b1;
                rom_word.seq_op      = ddr_pkg::SEQ_LOOP;
                rom_word.target      = STEP_ROTATE;
            end
            STEP_TRIG:
            begin
                rom_word.upd_sel = ddr_pkg::UPD_TRIG;
            end
            STEP_LAT:
            begin
                rom_word.mul_sel = ddr_pkg::MUL_LAT;
            end
            STEP_LON:
            begin
                rom_word.upd_sel = ddr_pkg::UPD_LAT;
                rom_word.mul_sel = ddr_pkg::MUL_LON;
            end
            STEP_MOVE:
            begin
                rom_word.upd_sel = ddr_pkg::UPD_LON;
            end
            STEP_EMIT:
            begin
                rom_word.seq_op = ddr_pkg::SEQ_EMIT;
            end
            default:
            begin
                rom_word = ddr_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign ctrl = (state_reg == ST_RUN) ? rom_word : ddr_pkg::CTRL_IDLE;
    assign emit = (state_reg == ST_RUN) && (rom_word.seq_op == ddr_pkg::SEQ_EMIT) && out_free;

    assign seq_stat.busy = (state_reg == ST_RUN);
    assign seq_stat.emit = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                        pc_reg    <= STEP_TURN;
                    end
                end
                ST_RUN:
                begin
                    case (rom_word.seq_op)
                        ddr_pkg::SEQ_LOOP:
                        begin
                            if (dp_stat.cordic_last)
                                pc_reg <= pc_reg + 1'b1;
                            else
                                pc_reg <= rom_word.target;
                        end
                        ddr_pkg::SEQ_EMIT:
                        begin
                            if (out_free)
                            begin
                                state_reg <= ST_IDLE;
                                pc_reg    <= STEP_TURN;
                            end
                        end
                        default:
                        begin
                            pc_reg <= pc_reg + 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/ddr_datapath.sv */
module ddr_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic signed [ddr_pkg::THR_W-1:0]      thr_left,
    input  logic signed [ddr_pkg::THR_W-1:0]      thr_right,
    input  logic        [ddr_pkg::IVL_W-1:0]      interval_ms,
    input  logic                                  cfg_we,
    input  logic        [ddr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ddr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ddr_pkg::ctrl_word_t                   ctrl,
    output ddr_pkg::dp_stat_t                     dp_stat,
    output logic signed [ddr_pkg::LAT_W-1:0]      latitude,
    output logic signed [ddr_pkg::LON_W-1:0]      longitude,
    output logic        [ddr_pkg::HEAD_W-1:0]     heading,
    output logic signed [ddr_pkg::SPEED_W-1:0]    speed
);

    localparam int THR_W   = ddr_pkg::THR_W;
    localparam int PROD_W  = ddr_pkg::PROD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CW      = ddr_pkg::CORDIC_W;
    localparam int ZW      = ddr_pkg::CORDIC_Z_W;
    localparam int TRIG_W  = ddr_pkg::TRIG_W;
    localparam int TRIG_SH = ddr_pkg::CORDIC_FRAC - ddr_pkg::TRIG_BITS;

    localparam logic signed [THR_W-1:0]  Q_POS = THR_W'(ddr_pkg::Q_ONE);
    localparam logic signed [THR_W-1:0]  Q_NEG = -Q_POS;
    localparam logic signed [PROD_W-1:0] HALF_GAIN = PROD_W'(1) << (ddr_pkg::GAIN_SH - 1);
    localparam logic signed [PROD_W-1:0] HALF_TRIG = PROD_W'(1) << (ddr_pkg::TRIG_BITS - 1);
    localparam logic signed [CW-1:0]     HALF_C    = CW'(1) << (TRIG_SH - 1);
    localparam logic signed [CW-1:0]     TRIG_LIM  = CW'(1) << ddr_pkg::TRIG_BITS;
    localparam logic signed [SUM_W-1:0]  LAT_LIM   = SUM_W'(ddr_pkg::LAT_MAX);
    localparam logic signed [SUM_W-1:0]  LON_LIM   = SUM_W'(ddr_pkg::LON_MAX);

    // configuration and state
    logic        [ddr_pkg::SG_W-1:0]    sg_reg;
    logic        [ddr_pkg::TG_W-1:0]    tg_reg;
    logic        [ddr_pkg::HEAD_W-1:0]  heading_reg, heading_next;
    logic signed [ddr_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic signed [ddr_pkg::LAT_W-1:0]   lat_reg, lat_next;
    logic signed [ddr_pkg::LON_W-1:0]   lon_reg, lon_next;

    // operands of one transaction
    logic signed [THR_W-1:0]            ml_reg, mr_reg, ml_clip, mr_clip;
    logic        [ddr_pkg::IVL_W-1:0]   ivl_reg;
    logic signed [THR_W:0]              thr_sum, thr_diff;

    // shared multiplier
    logic signed [ddr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ddr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           prod_reg, prod_next, prod_gain, prod_trig;
    logic signed [ddr_pkg::DIST_W-1:0]  dist_reg;
    logic signed [SUM_W-1:0]            lat_sum, lon_sum;

    // cordic rotator
    logic signed [CW-1:0]               x_reg, x_next, y_reg, y_next, x_sh, y_sh;
    logic signed [ZW-1:0]               z_reg, z_next, z_step;
    logic        [ddr_pkg::ITER_W-1:0]  iter_reg;
    logic signed [CW-1:0]               x_rnd, y_rnd, x_clamp, y_clamp;
    logic signed [TRIG_W-1:0]           c_val, s_val, cos_reg, cos_next, sin_reg, sin_next;

    always_comb
    begin
        if (thr_left < Q_NEG)
            ml_clip = Q_NEG;
        else if (thr_left > Q_POS)
            ml_clip = Q_POS;
        else
            ml_clip = thr_left;
        if (thr_right < Q_NEG)
            mr_clip = Q_NEG;
        else if (thr_right > Q_POS)
            mr_clip = Q_POS;
        else
            mr_clip = thr_right;
    end

    assign thr_sum  = (THR_W + 1)'(ml_reg) + (THR_W + 1)'(mr_reg);
    assign thr_diff = (THR_W + 1)'(mr_reg) - (THR_W + 1)'(ml_reg);

    // operand select for the multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            ddr_pkg::MUL_TURN:
            begin
                mul_a = ddr_pkg::MUL_A_W'(signed'({1'b0, tg_reg}));
                mul_b = ddr_pkg::MUL_B_W'(thr_diff);
            end
            ddr_pkg::MUL_SPEED:
            begin
                mul_a = ddr_pkg::MUL_A_W'(signed'({1'b0, sg_reg}));
                mul_b = ddr_pkg::MUL_B_W'(thr_sum);
            end
            ddr_pkg::MUL_DIST:
            begin
                mul_a = ddr_pkg::MUL_A_W'(speed_reg);
                mul_b = ddr_pkg::MUL_B_W'(signed'({1'b0, ivl_reg}));
            end
            ddr_pkg::MUL_LAT:
            begin
                mul_a = ddr_pkg::MUL_A_W'(dist_reg);
                mul_b = ddr_pkg::MUL_B_W'(cos_reg);
            end
            ddr_pkg::MUL_LON:
            begin
                mul_a = ddr_pkg::MUL_A_W'(dist_reg);
                mul_b = ddr_pkg::MUL_B_W'(sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up: add half, then floor
    assign prod_gain = (prod_reg + HALF_GAIN) >>> ddr_pkg::GAIN_SH;
    assign prod_trig = (prod_reg + HALF_TRIG) >>> ddr_pkg::TRIG_BITS;

    assign heading_next = heading_reg + prod_gain[ddr_pkg::HEAD_W-1:0];
    assign speed_next   = prod_gain[ddr_pkg::SPEED_W-1:0];

    assign lat_sum = SUM_W'(lat_reg) + SUM_W'(prod_trig);
    assign lon_sum = SUM_W'(lon_reg) + SUM_W'(prod_trig);

    always_comb
    begin
        if (lat_sum > LAT_LIM)
            lat_next = ddr_pkg::LAT_W'(LAT_LIM);
        else if (lat_sum < -LAT_LIM)
            lat_next = ddr_pkg::LAT_W'(-LAT_LIM);
        else
            lat_next = ddr_pkg::LAT_W'(lat_sum);
        if (lon_sum > LON_LIM)
            lon_next = ddr_pkg::LON_W'(LON_LIM);
        else if (lon_sum < -LON_LIM)
            lon_next = ddr_pkg::LON_W'(-LON_LIM);
        else
            lon_next = ddr_pkg::LON_W'(lon_sum);
    end

    // one rotation per step, direction from the sign of the residual angle
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign z_step = signed'(ZW'(ddr_pkg::atan_turn(iter_reg)));

    always_comb
    begin
        if (!z_reg[ZW-1])
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - z_step;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + z_step;
        end
    end

    assign dp_stat.cordic_last = (iter_reg == ddr_pkg::ITER_W'(ddr_pkg::CORDIC_ITERS - 1));

    // round to trig precision, clamp to unity, then fold in the quadrant
    assign x_rnd = (x_reg + HALF_C) >>> TRIG_SH;
    assign y_rnd = (y_reg + HALF_C) >>> TRIG_SH;

    always_comb
    begin
        if (x_rnd > TRIG_LIM)
            x_clamp = TRIG_LIM;
        else if (x_rnd < -TRIG_LIM)
            x_clamp = -TRIG_LIM;
        else
            x_clamp = x_rnd;
        if (y_rnd > TRIG_LIM)
            y_clamp = TRIG_LIM;
        else if (y_rnd < -TRIG_LIM)
            y_clamp = -TRIG_LIM;
        else
            y_clamp = y_rnd;
    end

    assign c_val = TRIG_W'(x_clamp);
    assign s_val = TRIG_W'(y_clamp);

    always_comb
    begin
        case (heading_reg[ddr_pkg::HEAD_W-1 -: 2])
            2'd0:
            begin
                cos_next = c_val;
                sin_next = s_val;
            end
            2'd1:
            begin
                cos_next = -s_val;
                sin_next = c_val;
            end
            2'd2:
            begin
                cos_next = -c_val;
                sin_next = -s_val;
            end
            default:
            begin
                cos_next = s_val;
                sin_next = -c_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg      <= ddr_pkg::SPEED_GAIN_RST;
            tg_reg      <= ddr_pkg::TURN_GAIN_RST;
            heading_reg <= '0;
            speed_reg   <= '0;
            lat_reg     <= '0;
            lon_reg     <= '0;
            iter_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ddr_pkg::REG_SPEED_GAIN: sg_reg <= cfg_data[ddr_pkg::SG_W-1:0];
                    ddr_pkg::REG_TURN_GAIN:  tg_reg <= cfg_data[ddr_pkg::TG_W-1:0];
                    default: ;
                endcase
            end
            case (ctrl.upd_sel)
                ddr_pkg::UPD_HEAD:  heading_reg <= heading_next;
                ddr_pkg::UPD_SPEED: speed_reg   <= speed_next;
                ddr_pkg::UPD_LAT:   lat_reg     <= lat_next;
                ddr_pkg::UPD_LON:   lon_reg     <= lon_next;
                default: ;
            endcase
            if (ctrl.cordic_init)
                iter_reg <= '0;
            else if (ctrl.cordic_step)
                iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ml_reg  <= ml_clip;
            mr_reg  <= mr_clip;
            ivl_reg <= interval_ms;
        end
        if (ctrl.mul_sel != ddr_pkg::MUL_NONE)
            prod_reg <= prod_next;
        if (ctrl.upd_sel == ddr_pkg::UPD_DIST)
            dist_reg <= prod_reg[ddr_pkg::DIST_W-1:0];
        if (ctrl.upd_sel == ddr_pkg::UPD_TRIG)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (ctrl.cordic_init)
        begin
            x_reg <= CW'(ddr_pkg::CORDIC_K0);
            y_reg <= '0;
            z_reg <= signed'(ZW'(heading_reg[ddr_pkg::CORDIC_FRAC-1:0]));
        end
        else if (ctrl.cordic_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign latitude  = lat_reg;
    assign longitude = lon_reg;
    assign heading   = heading_reg;
    assign speed     = speed_reg;

endmodule
